// File: hdl/ptsc_pkg.sv
// Shared types, codes and the phase transition rules of the per-thread sequence checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ptsc_pkg;

   localparam int THREAD_SLOTS_DEFAULT = 32768;
   localparam int TID_W  = 22;
   localparam int TIME_W = 64;
   localparam int RSP_W  = TID_W + TIME_W;

   typedef logic [3:0] phase_type;
   typedef logic [3:0] kind_type;

   // Phase codes kept in the table.
   localparam phase_type PHASE_IDLE       = 4'd0;
   localparam phase_type PHASE_IOCTL      = 4'd1;

   // Event kinds.
   localparam kind_type KIND_IOCTL        = 4'd0;
   localparam kind_type KIND_COMMAND      = 4'd1;
   localparam kind_type KIND_TXN          = 4'd2;
   localparam kind_type KIND_WRITE_DONE   = 4'd3;
   localparam kind_type KIND_WAIT_WORK    = 4'd4;
   localparam kind_type KIND_TXN_RECV     = 4'd5;
   localparam kind_type KIND_RETURN       = 4'd6;
   localparam kind_type KIND_READ_DONE    = 4'd7;
   localparam kind_type KIND_IOCTL_END    = 4'd8;
   localparam kind_type KIND_EXIT         = 4'd9;

   // Bit p of entry k is set when phase p may precede event kind k.
   // Padding phases above read_done are never set.
   localparam logic [15:0] ALLOWED_FROM [16] = '{
      16'h0000,   // ioctl: forced
      16'h000E,   // command    <- ioctl, command, txn
      16'h0004,   // txn        <- command
      16'h000C,   // write_done <- command, txn
      16'h0012,   // wait_work  <- ioctl, write_done
      16'h00A0,   // txn_recv   <- wait_work, return
      16'h00E0,   // return     <- wait_work, txn_recv, return
      16'h00A0,   // read_done  <- wait_work, return
      16'h0112,   // ioctl end  <- ioctl, write_done, read_done
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   typedef struct packed {
      logic      wr;      // phase changes
      logic      bad;     // event refused
      phase_type phase;   // new phase when wr is set
   } step_type;

   // Occupancy of the result queue, reported to the control logic.
   typedef struct packed {
      logic [1:0] count;
   } rspq_status_type;

   function automatic step_type phase_step(kind_type kind, phase_type cur);
      step_type r;
      r = '0;
      unique case (kind)
         KIND_IOCTL: begin
            r.wr    = 1'b1;
            r.phase = PHASE_IOCTL;
         end
         KIND_EXIT: begin
            r.wr    = 1'b1;
            r.phase = PHASE_IDLE;
         end
         default: begin
            if (ALLOWED_FROM[kind][cur]) begin
               r.wr    = 1'b1;
               r.phase = (kind == KIND_IOCTL_END) ? PHASE_IDLE : phase_type'(kind + 4'd1);
            end else begin
               r.bad   = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/ptsc_phase_mem.sv
// Phase table: one synchronous memory, one write port and one registered read port.
// Depends on ptsc_pkg for the phase type.
`default_nettype none

module ptsc_phase_mem #(
   parameter int DEPTH  = ptsc_pkg::THREAD_SLOTS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire  [ADDR_W-1:0]   wr_addr,
   input  ptsc_pkg::phase_type wr_data,
   input  wire                 rd_en,
   input  wire  [ADDR_W-1:0]   rd_addr,
   output ptsc_pkg::phase_type rd_data
);
   import ptsc_pkg::*;

   phase_type mem [DEPTH];
   phase_type rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/ptsc_rsp_queue.sv
// Two-entry queue that holds violation results until the result channel takes them.
// Depends on ptsc_pkg for the result width and the status struct.
`default_nettype none

module ptsc_rsp_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  wire  [ptsc_pkg::RSP_W-1:0]  push_data,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [ptsc_pkg::RSP_W-1:0]  rsp_data,
   output ptsc_pkg::rspq_status_type   status
);
   import ptsc_pkg::*;

   logic [RSP_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign wr_ptr_in  = wr_ptr_ff ^ push;
   assign rd_ptr_in  = rd_ptr_ff ^ pop;
   assign count_in   = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_tvalid   = (count_ff != 2'd0);
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

`default_nettype wire

// File: hdl/per_thread_sequence_checker_top.sv
// Top level of the per-thread sequence checker: event pipeline, phase table and result queue.
// Depends on ptsc_pkg, ptsc_phase_mem and ptsc_rsp_queue.
//
//   Channel   Direction  Transfer when             Contents
//   req_*     in         req_tvalid & req_tready  tuser: kind; tdata: thread_id, timestamp_ns
//   rsp_*     out        rsp_tvalid & rsp_tready  tdata: bad_thread, bad_time
//
// The input accepts one event per cycle unless it stalls. An accepted event reads its
// thread's phase from the table at once; in the next cycle the rules are applied and the
// new phase is written back, while the next event is already reading. A write made in the
// same cycle as a read of the same slot is forwarded, so back-to-back events of one thread
// see each other. After reset a clearing pass sets every slot to idle in turn and no event
// is accepted meanwhile. The input stalls only during the clearing pass, while the result
// queue is full, or while it holds one result and a refused event is about to add another.
`default_nettype none

module per_thread_sequence_checker_top #(
   parameter int THREAD_SLOTS = ptsc_pkg::THREAD_SLOTS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   // Event input.
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [87:0]  req_tdata,   // [21:0] thread_id, [85:22] timestamp_ns, [87:86] zero
   input  wire  [3:0]   req_tuser,   // [3:0] kind
   // Violation results.
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [87:0]  rsp_tdata    // [21:0] bad_thread, [85:22] bad_time, [87:86] zero
);
   import ptsc_pkg::*;

   localparam int ADDR_W = $clog2(THREAD_SLOTS);
   localparam logic [TID_W:0]    SLOTS_LIMIT = (TID_W+1)'(THREAD_SLOTS);
   localparam logic [ADDR_W-1:0] LAST_SLOT   = ADDR_W'(THREAD_SLOTS - 1);

   // Input fields.
   kind_type            req_kind;
   logic [TID_W-1:0]    req_tid;
   logic [TIME_W-1:0]   req_time;
   logic                req_fire;
   logic                req_relevant;

   assign req_kind = req_tuser;
   assign req_tid  = req_tdata[TID_W-1:0];
   assign req_time = req_tdata[RSP_W-1:TID_W];
   assign req_fire = req_tvalid & req_tready;

   // Out-of-range threads and unknown kinds pass through without effect.
   assign req_relevant = ({1'b0, req_tid} < SLOTS_LIMIT) && (req_kind <= KIND_EXIT);

   // Clearing pass after reset.
   logic                clearing_ff, clearing_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   assign clearing_in = clearing_ff && (clr_addr_ff != LAST_SLOT);
   assign clr_addr_in = clr_addr_ff + ADDR_W'(1);

   // Check stage: the event whose phase read is coming back this cycle.
   logic                s1_valid_ff, s1_valid_in;
   kind_type            s1_kind_ff;
   logic [TID_W-1:0]    s1_tid_ff;
   logic [TIME_W-1:0]   s1_time_ff;
   logic [ADDR_W-1:0]   s1_addr;

   // Last table write, for a read that overlapped it.
   logic                fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   phase_type           fwd_phase_ff;

   phase_type           mem_rd_data;
   phase_type           cur_phase;
   step_type            step;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   phase_type           mem_wr_data;

   logic                q_push;
   logic [RSP_W-1:0]    rsp_data;
   rspq_status_type     q_status;

   assign s1_valid_in  = req_fire & req_relevant;
   assign s1_addr      = s1_tid_ff[ADDR_W-1:0];

   assign cur_phase = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_phase_ff : mem_rd_data;
   assign step      = phase_step(s1_kind_ff, cur_phase);

   assign fwd_valid_in = s1_valid_ff & step.wr;
   assign q_push       = s1_valid_ff & step.bad;

   assign mem_wr_en   = clearing_ff | fwd_valid_in;
   assign mem_wr_addr = clearing_ff ? clr_addr_ff : s1_addr;
   assign mem_wr_data = clearing_ff ? PHASE_IDLE : step.phase;

   // Accept only when the queue is sure to have room for a result of this event.
   assign req_tready = !clearing_ff &&
                       ((q_status.count == 2'd0) ||
                        ((q_status.count == 2'd1) && !q_push));

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_kind;
         s1_tid_ff  <= req_tid;
         s1_time_ff <= req_time;
      end
      fwd_addr_ff  <= s1_addr;
      fwd_phase_ff <= step.phase;
   end

   ptsc_phase_mem #(
      .DEPTH   (THREAD_SLOTS)
   ) u_phase_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_tid[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   ptsc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({s1_time_ff, s1_tid_ff}),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .status     (q_status)
   );

   assign rsp_tdata = {2'b00, rsp_data};

   // The clearing pass and the check stage never write the table together.
   assert property (@(posedge clock) disable iff (reset) !(clearing_ff && s1_valid_ff))
      else $error("phase table written by clearing pass and check stage at once");

   // A refused event never meets a full result queue.
   assert property (@(posedge clock) disable iff (reset) !(q_push && (q_status.count == 2'd2)))
      else $error("result queue overflow");

   // After a refused event is pushed, the result channel is valid in the next cycle.
   assert property (@(posedge clock) disable iff (reset) q_push |=> rsp_tvalid)
      else $error("violation result missing");

   // Leaving reset always starts the clearing pass.
   assert property (@(posedge clock) $fell(reset) |-> clearing_ff)
      else $error("clearing pass not started after reset");

endmodule

`default_nettype wire

// File: sim/ptsc_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the per-thread sequence checker, predicts violations and compares.
// Depends on ptsc_pkg for widths and event kind codes.

module ptsc_checker #(
   parameter int THREAD_SLOTS = ptsc_pkg::THREAD_SLOTS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [87:0]  req_tdata,   // [21:0] thread_id, [85:22] timestamp_ns, [87:86] zero
   input  wire  [3:0]   req_tuser,   // [3:0] kind
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [87:0]  rsp_tdata,   // [21:0] bad_thread, [85:22] bad_time, [87:86] zero
   output int           fail_count,
   output int           pending_count
);
   import ptsc_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_IOCTL      = 4'd1,
      PH_COMMAND    = 4'd2,
      PH_TXN        = 4'd3,
      PH_WRITE_DONE = 4'd4,
      PH_WAIT_WORK  = 4'd5,
      PH_TXN_RECV   = 4'd6,
      PH_RETURN     = 4'd7,
      PH_READ_DONE  = 4'd8
   } protocol_phase_type;

   typedef struct {
      logic [TID_W-1:0]  bad_thread;
      logic [TIME_W-1:0] bad_time;
   } violation_type;

   phase_type     thread_phase [THREAD_SLOTS];
   violation_type expected_violations [$];
   int            mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Phases from which an event of the given kind is legal.
   function automatic logic may_follow(kind_type kind, phase_type cur);
      case (kind)
         KIND_COMMAND:    return cur == PH_IOCTL || cur == PH_COMMAND || cur == PH_TXN;
         KIND_TXN:        return cur == PH_COMMAND;
         KIND_WRITE_DONE: return cur == PH_COMMAND || cur == PH_TXN;
         KIND_WAIT_WORK:  return cur == PH_IOCTL || cur == PH_WRITE_DONE;
         KIND_TXN_RECV:   return cur == PH_WAIT_WORK || cur == PH_RETURN;
         KIND_RETURN:     return cur == PH_WAIT_WORK || cur == PH_TXN_RECV || cur == PH_RETURN;
         KIND_READ_DONE:  return cur == PH_WAIT_WORK || cur == PH_RETURN;
         KIND_IOCTL_END:  return cur == PH_IOCTL || cur == PH_WRITE_DONE || cur == PH_READ_DONE;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic phase_type phase_after(kind_type kind);
      case (kind)
         KIND_COMMAND:    return PH_COMMAND;
         KIND_TXN:        return PH_TXN;
         KIND_WRITE_DONE: return PH_WRITE_DONE;
         KIND_WAIT_WORK:  return PH_WAIT_WORK;
         KIND_TXN_RECV:   return PH_TXN_RECV;
         KIND_RETURN:     return PH_RETURN;
         KIND_READ_DONE:  return PH_READ_DONE;
         default:         return PH_IDLE;
      endcase
   endfunction

   always @(posedge clock) begin
      kind_type          kind;
      logic [TID_W-1:0]  tid;
      logic [TIME_W-1:0] stamp;
      logic [TID_W-1:0]  got_thread;
      logic [TIME_W-1:0] got_time;
      violation_type     want;
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) thread_phase[i] = PH_IDLE;
         expected_violations.delete();
      end else begin
         // Results come out later than their events, so the result side goes first.
         if (rsp_tvalid && rsp_tready) begin
            got_thread = rsp_tdata[TID_W-1:0];
            got_time   = rsp_tdata[TID_W +: TIME_W];
            if (expected_violations.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected violation, expected none, got thread %0d time %h",
                           $time, got_thread, got_time);
               mismatches++;
            end else begin
               want = expected_violations.pop_front();
               if (want.bad_thread !== got_thread || want.bad_time !== got_time) begin
                  if (mismatches < 10)
                     $display("%0t: violation mismatch, thread exp %0d got %0d, time exp %h got %h",
                              $time, want.bad_thread, got_thread, want.bad_time, got_time);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            kind  = req_tuser;
            tid   = req_tdata[TID_W-1:0];
            stamp = req_tdata[TID_W +: TIME_W];
            // Out-of-range threads and unknown kinds leave no trace.
            if (tid < THREAD_SLOTS && kind <= KIND_EXIT) begin
               if (kind == KIND_IOCTL)
                  thread_phase[tid] = PH_IOCTL;
               else if (kind == KIND_EXIT)
                  thread_phase[tid] = PH_IDLE;
               else if (may_follow(kind, thread_phase[tid]))
                  thread_phase[tid] = phase_after(kind);
               else
                  expected_violations.push_back('{tid, stamp});
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_violations.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the per-thread sequence checker testbench: clock, reset, event stimulus and verdict.
// Depends on ptsc_pkg, per_thread_sequence_checker_top and ptsc_checker.

module testbench;
   import ptsc_pkg::*;

   localparam int THREAD_SLOTS = THREAD_SLOTS_DEFAULT;
   // The block clears its whole phase table after reset before it takes any event,
   // so the watchdog must comfortably outlast that pass as well as the long hold-off.
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_EVENTS  = 900;

   typedef struct {
      kind_type          kind;
      logic [TID_W-1:0]  tid;
      logic [TIME_W-1:0] stamp;
   } event_item_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   logic [87:0]  req_tdata  = '0;   // [21:0] thread_id, [85:22] timestamp_ns, [87:86] zero
   logic [3:0]   req_tuser  = '0;   // [3:0] kind
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   wire  [87:0]  rsp_tdata;         // [21:0] bad_thread, [85:22] bad_time, [87:86] zero

   int fail_count;
   int pending_count;

   // Counts events that reach the phase table; ignored ones do not add to it.
   int useful_events = 0;
   // Number of upcoming events that go out with no gap at all.
   int calm_events   = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   logic hold_request = 1'b0;
   logic hold_taken   = 1'b0;
   int   idle_cycles  = 0;

   event_item_type draft  [$];
   event_item_type lane_a [$];
   event_item_type lane_b [$];

   always #5 clock = ~clock;

   per_thread_sequence_checker_top #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ptsc_checker #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TIME_W-1:0] random_stamp();
      return {$urandom, $urandom};
   endfunction

   // Most traffic goes to a handful of threads so that sessions build real history;
   // the top slot and the rest of the table get their share too.
   function automatic logic [TID_W-1:0] pick_thread();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return TID_W'($urandom_range(0, 7));
      if (r < 90) return TID_W'(THREAD_SLOTS - 1);
      return TID_W'($urandom_range(0, THREAD_SLOTS - 1));
   endfunction

   function automatic event_item_type make_item(kind_type kind, logic [TID_W-1:0] tid);
      event_item_type it;
      it.kind  = kind;
      it.tid   = tid;
      it.stamp = random_stamp();
      return it;
   endfunction

   // Offers one event and returns at the rising edge of its transfer. A gap, if any,
   // is spent with tvalid low; without one, tvalid simply stays high for the next event.
   task automatic offer_event(event_item_type it);
      int gap;
      if (calm_events > 0) begin
         gap = 0;
         calm_events--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 63) == 0) calm_events = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {2'b00, it.stamp, it.tid};
      do @(posedge clock); while (!req_tready);
      if (it.tid < THREAD_SLOTS && it.kind <= KIND_EXIT) useful_events++;
   endtask

   // Random kind, often to a thread outside the table; this also walks every thread_id bit.
   task automatic offer_noise();
      event_item_type it;
      int             r;
      r = $urandom_range(0, 99);
      it.kind  = kind_type'($urandom_range(0, 15));
      it.stamp = random_stamp();
      if (r < 50)
         it.tid = pick_thread();
      else if (r < 75)
         it.tid = TID_W'($urandom_range(THREAD_SLOTS, 22'h3FFFFF));
      else
         it.tid = TID_W'($urandom);
      offer_event(it);
   endtask

   // Appends one well-formed session of a thread to draft: an ioctl, an optional write
   // part with command/txn loops, an optional read part with txn_recv/return loops, and
   // an ioctl end event to close (sometimes exit instead).
   task automatic build_session(logic [TID_W-1:0] tid);
      int       n;
      kind_type last;
      logic     has_write;
      draft.push_back(make_item(KIND_IOCTL, tid));
      has_write = ($urandom_range(0, 3) != 0);
      if (has_write) begin
         last = KIND_COMMAND;
         draft.push_back(make_item(last, tid));
         n = $urandom_range(0, 4);
         repeat (n) begin
            if (last == KIND_COMMAND && $urandom_range(0, 1) == 1) last = KIND_TXN;
            else last = KIND_COMMAND;
            draft.push_back(make_item(last, tid));
         end
         draft.push_back(make_item(KIND_WRITE_DONE, tid));
      end
      if (!has_write || $urandom_range(0, 2) != 0) begin
         draft.push_back(make_item(KIND_WAIT_WORK, tid));
         last = KIND_WAIT_WORK;
         n = $urandom_range(0, 5);
         repeat (n) begin
            if (last != KIND_TXN_RECV && $urandom_range(0, 1) == 1) last = KIND_TXN_RECV;
            else last = KIND_RETURN;
            draft.push_back(make_item(last, tid));
         end
         // read_done may not follow txn_recv directly.
         if (last == KIND_TXN_RECV) draft.push_back(make_item(KIND_RETURN, tid));
         draft.push_back(make_item(KIND_READ_DONE, tid));
      end
      if ($urandom_range(0, 5) == 0) draft.push_back(make_item(KIND_EXIT, tid));
      else draft.push_back(make_item(KIND_IOCTL_END, tid));
   endtask

   // One or two sessions on different threads, interleaved at random. A small share
   // of their events is corrupted, dropped or preceded by noise, which breaks sequences.
   task automatic run_sessions();
      logic [TID_W-1:0] tid_a;
      logic [TID_W-1:0] tid_b;
      event_item_type   it;
      int               r;
      tid_a = pick_thread();
      draft = {};
      build_session(tid_a);
      lane_a = draft;
      lane_b = {};
      if ($urandom_range(0, 1) == 1) begin
         tid_b = pick_thread();
         if (tid_b != tid_a) begin
            draft = {};
            build_session(tid_b);
            lane_b = draft;
         end
      end
      while (lane_a.size() != 0 || lane_b.size() != 0) begin
         if (lane_b.size() == 0 || (lane_a.size() != 0 && $urandom_range(0, 1) == 1))
            it = lane_a.pop_front();
         else
            it = lane_b.pop_front();
         r = $urandom_range(0, 99);
         if (r < 5) begin
            it.kind = kind_type'($urandom_range(0, 15));
            offer_event(it);
         end else if (r < 8) begin
            offer_noise();
            offer_event(it);
         end else if (r >= 11) begin
            offer_event(it);
         end
      end
   endtask

   // Receiver: ready most of the time with random stalls, calm stretches without any,
   // and one long hold-off when the stimulus asks for it.
   initial begin
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            stall_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 199) == 0)
               calm_left = $urandom_range(40, 150);
            else
               stall_left = pick_gap();
         end
      end
   end

   // Watchdog: any transfer on either side restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [TID_W-1:0] top_slot;
      top_slot = TID_W'(THREAD_SLOTS - 1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Thread 0 walks the whole protocol, starting with a command from
      // idle, which must be refused, and later a repeated txn_recv, also refused.
      offer_event('{KIND_COMMAND,    22'd0, 64'd0});
      offer_event('{KIND_IOCTL,      22'd0, {TIME_W{1'b1}}});
      offer_event(make_item(KIND_IOCTL_END,  22'd0));
      offer_event(make_item(KIND_IOCTL,      22'd0));
      offer_event(make_item(KIND_COMMAND,    22'd0));
      offer_event(make_item(KIND_COMMAND,    22'd0));
      offer_event(make_item(KIND_TXN,        22'd0));
      offer_event(make_item(KIND_WRITE_DONE, 22'd0));
      offer_event(make_item(KIND_WAIT_WORK,  22'd0));
      offer_event(make_item(KIND_TXN_RECV,   22'd0));
      offer_event('{KIND_TXN_RECV,   22'd0, {TIME_W{1'b1}}});
      offer_event(make_item(KIND_RETURN,     22'd0));
      offer_event(make_item(KIND_TXN_RECV,   22'd0));
      offer_event(make_item(KIND_RETURN,     22'd0));
      offer_event(make_item(KIND_READ_DONE,  22'd0));
      offer_event(make_item(KIND_IOCTL_END,  22'd0));
      // Top slot of the table: a refused write_done after ioctl, then exit from a busy
      // phase, after which txn is refused from idle.
      offer_event(make_item(KIND_IOCTL,      top_slot));
      offer_event(make_item(KIND_WRITE_DONE, top_slot));
      offer_event(make_item(KIND_EXIT,       top_slot));
      offer_event(make_item(KIND_TXN,        top_slot));
      // Unknown kinds and threads beyond the table are ignored.
      offer_event(make_item(kind_type'(4'd10), 22'd0));
      offer_event(make_item(kind_type'(4'd15), 22'd0));
      offer_event(make_item(KIND_COMMAND,    22'(THREAD_SLOTS)));
      offer_event('{KIND_COMMAND, 22'h3FFFFF, 64'd0});

      // Back-pressure: the receiver holds off for a long stretch while commands to idle
      // threads keep producing violations, so the result queue fills and the input stalls.
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) offer_event(make_item(KIND_COMMAND, 22'(100 + i)));

      // Random part: mostly interleaved well-formed sessions, the rest noise.
      useful_events = 0;
      while (useful_events < RANDOM_EVENTS) begin
         if ($urandom_range(0, 99) < 12) offer_noise();
         else run_sessions();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain: wait for every predicted violation, then a few more cycles so that any
      // stray result would still show up before the verdict.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: per_thread_sequence_checker_top.f
hdl/ptsc_pkg.sv
hdl/ptsc_phase_mem.sv
hdl/ptsc_rsp_queue.sv
hdl/per_thread_sequence_checker_top.sv
sim/ptsc_checker.sv
sim/testbench.sv
